FILE: design/cec_pkg.sv
// Shared types, codes and helper functions for the record envelope checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cec_pkg;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTRW  = $clog2(QDEPTH);
   localparam int QCNTW  = $clog2(QDEPTH + 1);

   // header parser phases
   localparam logic [3:0] PH_MAGIC   = 4'd0;
   localparam logic [3:0] PH_LIT_V   = 4'd1;
   localparam logic [3:0] PH_NUM_V   = 4'd2;
   localparam logic [3:0] PH_LIT_LEN = 4'd3;
   localparam logic [3:0] PH_NUM_LEN = 4'd4;
   localparam logic [3:0] PH_LIT_CRC = 4'd5;
   localparam logic [3:0] PH_NUM_CRC = 4'd6;
   localparam logic [3:0] PH_SKIP    = 4'd7;
   localparam logic [3:0] PH_BODY    = 4'd8;

   // header field selectors
   localparam logic [1:0] FLD_VER = 2'd0;
   localparam logic [1:0] FLD_LEN = 2'd1;
   localparam logic [1:0] FLD_CRC = 2'd2;

   // verdict codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NO_NL   = 3'd1;
   localparam logic [2:0] ST_BAD_HDR = 3'd2;
   localparam logic [2:0] ST_LEN     = 3'd3;
   localparam logic [2:0] ST_CRC     = 3'd4;

   localparam logic [3:0]  MAGIC_LEN  = 4'd9;
   localparam logic [7:0]  CHAR_NL    = 8'h0A;
   localparam logic [4:0]  DIGIT_NONE = 5'd31;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

   // one queued piece of work: an optional body word and an optional verdict
   typedef struct packed {
      logic        has_body;
      logic [7:0]  body_byte;
      logic        has_verdict;
      logic [2:0]  status;
      logic [15:0] version;
      logic [31:0] length;
      logic [31:0] crc;
   } entry_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      end
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   // value of a hex or decimal digit, DIGIT_NONE for anything else
   function automatic logic [4:0] digit_val(input logic [7:0] c);
      logic [4:0] d;
      if (c inside {[8'h30:8'h39]}) begin
         d = {1'b0, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         d = {1'b0, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         d = {1'b0, 4'(c - 8'h37)};
      end else begin
         d = DIGIT_NONE;
      end
      return d;
   endfunction

   // magic token, one character per position
   function automatic logic [7:0] magic_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = 8'h4F;
         4'd1: ch = 8'h4D;
         4'd2: ch = 8'h4F;
         4'd3: ch = 8'h54;
         4'd4: ch = 8'h45;
         4'd5: ch = 8'h43;
         4'd6: ch = 8'h46;
         4'd7: ch = 8'h47;
         4'd8: ch = 8'h31;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [3:0] lit_len(input logic [1:0] f);
      logic [3:0] n;
      case (f)
         FLD_VER: n = 4'd2;
         FLD_LEN: n = 4'd4;
         FLD_CRC: n = 4'd6;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // field literals: "v=", "len=", "crc=0x"
   function automatic logic [7:0] lit_char(input logic [1:0] f, input logic [3:0] pos);
      logic [7:0] ch;
      case ({f, pos})
         {FLD_VER, 4'd0}: ch = 8'h76;
         {FLD_VER, 4'd1}: ch = 8'h3D;
         {FLD_LEN, 4'd0}: ch = 8'h6C;
         {FLD_LEN, 4'd1}: ch = 8'h65;
         {FLD_LEN, 4'd2}: ch = 8'h6E;
         {FLD_LEN, 4'd3}: ch = 8'h3D;
         {FLD_CRC, 4'd0}: ch = 8'h63;
         {FLD_CRC, 4'd1}: ch = 8'h72;
         {FLD_CRC, 4'd2}: ch = 8'h63;
         {FLD_CRC, 4'd3}: ch = 8'h3D;
         {FLD_CRC, 4'd4}: ch = 8'h30;
         {FLD_CRC, 4'd5}: ch = 8'h78;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: design/config_envelope_checker_unit.sv
// Top level of the record envelope checker: front end, queue and output stage.
// Depends on cec_pkg, cec_front, cec_queue and cec_back.
//
// Usage
//   The req channel takes one record byte per word; req_tlast marks the final
//   byte of a record. Bytes up to the first newline form the text header
//   (magic token, v=, len=, crc=0x fields). Every later byte is a body byte.
//   The rsp channel returns one word per body byte (rsp_tlast low, byte in
//   the low eight bits) and, after the final byte, one verdict word
//   (rsp_tlast high) with status, version, body length and body CRC.
// Timing
//   A byte is taken every cycle while req_tready is high. Parsing, the byte-
//   wide CRC step and the count update happen in the cycle the byte is
//   accepted. Its words pass the queue and output register; the output stage
//   sends one word a cycle while rsp_tready is high, body word before verdict.
// Reset
//   Synchronous reset empties the queue, drops any pending word and returns
//   the parser to the start of a header, CRC to all ones. After each verdict
//   the parser returns to that state on its own.
// Stalls
//   When rsp_tready is low the current word holds; a four-entry queue keeps
//   absorbing work, and req_tready drops only when the queue is full.
`default_nettype none

module config_envelope_checker_unit
   import cec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_record
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] body_byte, [10:8] status, [26:11] schema_version,
   // [58:27] body_length, [90:59] body_crc, [95:91] zero
   output logic [95:0]      rsp_tdata,
   output logic             rsp_tlast    // kind: high on the verdict word
);

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   entry_type push_entry;
   entry_type pop_entry;

   // parse, count and CRC; push one entry per body byte or record end
   cec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (push_entry)
   );

   // decouple the two sides
   cec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (pop_entry)
   );

   // advance entries into output words
   cec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_last  (rsp_tlast),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: design/cec_front.sv
// Front end: accepts record bytes, parses the header, runs the body CRC and
// count, and builds queue entries. Depends on cec_pkg.
`default_nettype none

module cec_front
   import cec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output logic            in_ready,
   input  wire logic       q_full,
   output logic            push,
   output entry_type       push_entry
);

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  tpos_ff, tpos_in;
   logic [31:0] ver_ff, ver_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        herr_ff, herr_in;

   logic        accept;
   logic        lit_go;
   logic [1:0]  lit_f;
   logic [3:0]  ph_m1;
   logic [1:0]  num_f;
   logic        base16;
   logic [4:0]  dig;
   logic        dig_ok;
   logic [31:0] cur_val;
   logic [35:0] prod;
   logic [35:0] acc;
   logic        nl_done;
   logic [31:0] crc_final;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // number-field helpers
   assign ph_m1  = phase_ff - 4'd1;
   assign num_f  = ph_m1[2:1];
   assign base16 = (num_f == FLD_CRC);
   assign dig    = digit_val(in_byte);
   assign dig_ok = base16 ? (dig < 5'd16) : (dig < 5'd10);

   always_comb begin
      case (num_f)
         FLD_VER: cur_val = ver_ff;
         FLD_LEN: cur_val = len_ff;
         default: cur_val = exp_ff;
      endcase
   end

   assign prod = base16 ? {cur_val, 4'd0} : ({1'b0, cur_val, 3'd0} + {3'd0, cur_val, 1'b0});
   assign acc  = prod + {32'd0, dig[3:0]};

   assign nl_done = ((phase_ff == PH_SKIP) && !herr_ff) ||
                    ((phase_ff == PH_NUM_CRC) && (tpos_ff == 4'd1));

   always_comb begin
      phase_in = phase_ff;
      tpos_in  = tpos_ff;
      ver_in   = ver_ff;
      len_in   = len_ff;
      exp_in   = exp_ff;
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      herr_in  = herr_ff;
      lit_go   = 1'b0;
      lit_f    = FLD_VER;
      if (phase_ff == PH_BODY) begin
         crc_in = crc_byte(crc_ff, in_byte);
         cnt_in = cnt_ff + 32'd1;
      end else if (in_byte == CHAR_NL) begin
         if (!nl_done) herr_in = 1'b1;
         phase_in = PH_BODY;
         tpos_in  = 4'd0;
      end else begin
         case (phase_ff)
            PH_MAGIC: begin
               if (tpos_ff == 4'd0 && is_ws(in_byte)) begin
                  tpos_in = tpos_ff;
               end else if (tpos_ff < MAGIC_LEN) begin
                  if (in_byte == magic_char(tpos_ff)) begin
                     tpos_in = tpos_ff + 4'd1;
                  end else begin
                     herr_in  = 1'b1;
                     phase_in = PH_SKIP;
                  end
               end else if (is_ws(in_byte)) begin
                  phase_in = PH_LIT_V;
                  tpos_in  = 4'd0;
               end else begin
                  herr_in  = 1'b1;
                  phase_in = PH_SKIP;
               end
            end
            PH_LIT_V, PH_LIT_LEN, PH_LIT_CRC: begin
               lit_go = 1'b1;
               lit_f  = phase_ff[2:1];
            end
            PH_NUM_V, PH_NUM_LEN, PH_NUM_CRC: begin
               if (dig_ok) begin
                  if (acc[35:32] != 4'd0) begin
                     herr_in  = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     case (num_f)
                        FLD_VER: ver_in = acc[31:0];
                        FLD_LEN: len_in = acc[31:0];
                        default: exp_in = acc[31:0];
                     endcase
                     tpos_in = 4'd1;
                  end
               end else if (tpos_ff == 4'd0) begin
                  if (!is_ws(in_byte)) begin
                     herr_in  = 1'b1;
                     phase_in = PH_SKIP;
                  end
               end else if (num_f != FLD_CRC) begin
                  // number ended: the same byte opens the next literal
                  phase_in = phase_ff + 4'd1;
                  tpos_in  = 4'd0;
                  lit_go   = 1'b1;
                  lit_f    = num_f + 2'd1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (lit_go) begin
            if (tpos_in == 4'd0 && is_ws(in_byte)) begin
               tpos_in = 4'd0;
            end else if (tpos_in < lit_len(lit_f) && in_byte == lit_char(lit_f, tpos_in)) begin
               tpos_in = tpos_in + 4'd1;
               if (tpos_in == lit_len(lit_f)) begin
                  phase_in = phase_in + 4'd1;
                  tpos_in  = 4'd0;
               end
            end else begin
               herr_in  = 1'b1;
               phase_in = PH_SKIP;
            end
         end
      end
   end

   assign crc_final = ~crc_in;

   always_comb begin
      push_entry.has_body    = (phase_ff == PH_BODY);
      push_entry.body_byte   = in_byte;
      push_entry.has_verdict = in_last;
      if (phase_in != PH_BODY) begin
         push_entry.status = ST_NO_NL;
      end else if (herr_in) begin
         push_entry.status = ST_BAD_HDR;
      end else if (cnt_in != len_in) begin
         push_entry.status = ST_LEN;
      end else if (crc_final != exp_in) begin
         push_entry.status = ST_CRC;
      end else begin
         push_entry.status = ST_OK;
      end
      push_entry.version = (push_entry.status == ST_OK) ? ver_in[15:0] : 16'd0;
      push_entry.length  = cnt_in;
      push_entry.crc     = crc_final;
   end

   assign push = accept && ((phase_ff == PH_BODY) || in_last);

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         phase_ff <= PH_MAGIC;
         tpos_ff  <= 4'd0;
         ver_ff   <= 32'd0;
         len_ff   <= 32'd0;
         exp_ff   <= 32'd0;
         crc_ff   <= CRC_INIT;
         cnt_ff   <= 32'd0;
         herr_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tpos_ff  <= tpos_in;
         ver_ff   <= ver_in;
         len_ff   <= len_in;
         exp_ff   <= exp_in;
         crc_ff   <= crc_in;
         cnt_ff   <= cnt_in;
         herr_ff  <= herr_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/cec_queue.sv
// Short register queue between the front end and the output stage.
// Depends on cec_pkg for the entry type and depth.
`default_nettype none

module cec_queue
   import cec_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output entry_type      pop_entry
);

   entry_type        mem_ff [QDEPTH];
   logic [QPTRW-1:0] wr_ff, wr_in;
   logic [QPTRW-1:0] rd_ff, rd_in;
   logic [QCNTW-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (cnt_ff == QCNTW'(QDEPTH));
   assign empty     = (cnt_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTRW'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTRW'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/cec_back.sv
// Output stage: holds one queue entry and plays it out as one or two words,
// body word first. Depends on cec_pkg.
`default_nettype none

module cec_back
   import cec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_empty,
   input  wire entry_type    q_entry,
   output logic              q_pop,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic              out_last,
   output logic [95:0]       out_data
);

   entry_type cur_ff, cur_in;
   logic      body_pend_ff, body_pend_in;
   logic      verd_pend_ff, verd_pend_in;
   logic      take;
   logic      finishing;
   logic      idle;

   assign out_valid = body_pend_ff || verd_pend_ff;
   assign take      = out_valid && out_ready;
   assign idle      = !out_valid;
   assign finishing = take && !(body_pend_ff && verd_pend_ff);
   assign q_pop     = !q_empty && (idle || finishing);

   always_comb begin
      cur_in       = cur_ff;
      body_pend_in = body_pend_ff;
      verd_pend_in = verd_pend_ff;
      if (q_pop) begin
         cur_in       = q_entry;
         body_pend_in = q_entry.has_body;
         verd_pend_in = q_entry.has_verdict;
      end else if (take) begin
         if (body_pend_ff && verd_pend_ff) begin
            body_pend_in = 1'b0;
         end else begin
            body_pend_in = 1'b0;
            verd_pend_in = 1'b0;
         end
      end
   end

   // body word carries only the byte; verdict word carries everything else
   always_comb begin
      if (body_pend_ff) begin
         out_last = 1'b0;
         out_data = {88'd0, cur_ff.body_byte};
      end else begin
         out_last = 1'b1;
         out_data = {5'd0, cur_ff.crc, cur_ff.length, cur_ff.version, cur_ff.status, 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_pend_ff <= 1'b0;
         verd_pend_ff <= 1'b0;
      end else begin
         body_pend_ff <= body_pend_in;
         verd_pend_ff <= verd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

FILE: tb/sv/envelope_monitor.sv
// Watches both streams of the record envelope checker, forecasts every rsp word
// from the accepted req words and compares them field by field.
// Depends on cec_pkg for the phase, field and verdict codes.
`timescale 1ns / 1ps

module envelope_monitor
   import cec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_record
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] body_byte, [10:8] status, [26:11] schema_version,
   // [58:27] body_length, [90:59] body_crc, [95:91] zero
   input  wire logic [95:0] rsp_tdata,
   input  wire logic        rsp_tlast,   // kind
   output int unsigned      fault_count,
   output int unsigned      pending_count
);

   // the nine-character magic token, first character in the top byte
   localparam logic [71:0] MAGIC_WORD = 72'h4F_4D_4F_54_45_43_46_47_31;

   typedef struct packed {
      logic        kind;
      logic [7:0]  body_byte;
      logic [2:0]  status;
      logic [15:0] version;
      logic [31:0] length;
      logic [31:0] crc;
   } envelope_word_type;

   envelope_word_type due_words [$];
   envelope_word_type due_head;
   int unsigned       faults = 0;

   // forecast copy of the parser state
   logic [3:0]  phase;
   logic [3:0]  tok_pos;
   logic [31:0] ver_acc;
   logic [31:0] len_acc;
   logic [31:0] crc_want;
   logic [31:0] crc_run;
   logic [31:0] body_seen;
   logic        hdr_bad;

   initial fault_count = 0;
   initial pending_count = 0;

   function automatic logic blank_char(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic int unsigned digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
      return 99;
   endfunction

   function automatic string field_text(input logic [1:0] f);
      case (f)
         FLD_VER: return "v=";
         FLD_LEN: return "len=";
         default: return "crc=0x";
      endcase
   endfunction

   task automatic clear_envelope();
      phase     = PH_MAGIC;
      tok_pos   = 4'd0;
      ver_acc   = 32'd0;
      len_acc   = 32'd0;
      crc_want  = 32'd0;
      crc_run   = CRC_INIT;
      body_seen = 32'd0;
      hdr_bad   = 1'b0;
   endtask

   task automatic reject_header();
      hdr_bad = 1'b1;
      phase   = PH_SKIP;
   endtask

   // one header character; a number ended by a literal is re-run in the next phase
   task automatic parse_header_char(input logic [7:0] c);
      logic        again;
      logic [1:0]  f;
      int unsigned radix;
      int unsigned d;
      logic [31:0] v;
      string       lit;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         f = 2'((phase - 4'd1) >> 1);
         if (phase == PH_MAGIC) begin
            if (!(tok_pos == 4'd0 && blank_char(c))) begin
               if (tok_pos < 4'd9) begin
                  if (c == MAGIC_WORD[71 - 8 * int'(tok_pos) -: 8]) tok_pos = tok_pos + 4'd1;
                  else reject_header();
               end else if (blank_char(c)) begin
                  phase   = PH_LIT_V;
                  tok_pos = 4'd0;
               end else begin
                  reject_header();
               end
            end
         end else if (phase >= PH_LIT_V && phase <= PH_NUM_CRC && phase[0]) begin
            lit = field_text(f);
            if (!(tok_pos == 4'd0 && blank_char(c))) begin
               if (int'(tok_pos) < lit.len() && c == 8'(lit[int'(tok_pos)])) begin
                  tok_pos = tok_pos + 4'd1;
                  if (int'(tok_pos) == lit.len()) begin
                     phase   = phase + 4'd1;
                     tok_pos = 4'd0;
                  end
               end else begin
                  reject_header();
               end
            end
         end else if (phase >= PH_LIT_V && phase <= PH_NUM_CRC) begin
            radix = (f == FLD_CRC) ? 16 : 10;
            d     = digit_value(c);
            if (d < radix) begin
               v = (f == FLD_VER) ? ver_acc : (f == FLD_LEN) ? len_acc : crc_want;
               if (v > (32'hFFFF_FFFF - d) / radix) begin
                  reject_header();
               end else begin
                  v = v * radix + d;
                  if (f == FLD_VER) ver_acc = v;
                  else if (f == FLD_LEN) len_acc = v;
                  else crc_want = v;
                  tok_pos = 4'd1;
               end
            end else if (tok_pos == 4'd0) begin
               if (!blank_char(c)) reject_header();
            end else if (f != FLD_CRC) begin
               phase   = phase + 4'd1;
               tok_pos = 4'd0;
               again   = 1'b1;
            end else begin
               phase = PH_SKIP;
            end
         end
      end
   endtask

   // advance the forecast by one req word and queue the words it causes
   task automatic forecast_word(input logic [7:0] c, input logic last);
      envelope_word_type w;
      logic [31:0]       crc_out;
      logic [2:0]        st;
      if (phase == PH_BODY) begin
         crc_run = crc_run ^ {24'd0, c};
         for (int i = 0; i < 8; i++) crc_run = (crc_run >> 1) ^ (CRC_POLY & {32{crc_run[0]}});
         body_seen = body_seen + 32'd1;
         w = '0;
         w.body_byte = c;
         due_words.push_back(w);
      end else if (c == CHAR_NL) begin
         if (!((phase == PH_SKIP && !hdr_bad) || (phase == PH_NUM_CRC && tok_pos == 4'd1)))
            hdr_bad = 1'b1;
         phase   = PH_BODY;
         tok_pos = 4'd0;
      end else begin
         parse_header_char(c);
      end
      if (last) begin
         crc_out = ~crc_run;
         if (phase != PH_BODY) st = ST_NO_NL;
         else if (hdr_bad) st = ST_BAD_HDR;
         else if (body_seen != len_acc) st = ST_LEN;
         else if (crc_out != crc_want) st = ST_CRC;
         else st = ST_OK;
         w = '0;
         w.kind    = 1'b1;
         w.status  = st;
         w.version = (st == ST_OK) ? ver_acc[15:0] : 16'd0;
         w.length  = body_seen;
         w.crc     = crc_out;
         due_words.push_back(w);
         clear_envelope();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         faults++;
      end
   endtask

   initial clear_envelope();

   always @(posedge clock) begin
      if (reset) begin
         clear_envelope();
         due_words.delete();
      end else begin
         if (req_tvalid && req_tready) forecast_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (due_words.size() == 0) begin
               $error("rsp word %h (tlast %b) arrived with nothing due", rsp_tdata, rsp_tlast);
               faults++;
            end else begin
               due_head = due_words.pop_front();
               compare_field("kind", 32'(due_head.kind), 32'(rsp_tlast));
               compare_field("body_byte", 32'(due_head.body_byte), 32'(rsp_tdata[7:0]));
               compare_field("status", 32'(due_head.status), 32'(rsp_tdata[10:8]));
               compare_field("schema_version", 32'(due_head.version), 32'(rsp_tdata[26:11]));
               compare_field("body_length", due_head.length, rsp_tdata[58:27]);
               compare_field("body_crc", due_head.crc, rsp_tdata[90:59]);
               compare_field("padding", 32'd0, 32'(rsp_tdata[95:91]));
            end
         end
      end
      fault_count   <= faults;
      pending_count <= due_words.size();
   end

endmodule

FILE: tb/sv/testbench.sv
// Top of the record envelope checker testbench: clock, reset, record stimulus,
// rsp back-pressure, watchdog and verdict. Depends on cec_pkg, the block and
// envelope_monitor, which does all forecasting and comparing.
`timescale 1ns / 1ps

module testbench
   import cec_pkg::*;
;

   localparam logic [71:0] MAGIC_WORD   = 72'h4F_4D_4F_54_45_43_46_47_31;
   localparam int unsigned WORD_TARGET  = 740;   // stop offering records past this
   localparam int unsigned QUIET_AFTER  = 620;   // no idling from here on
   localparam int unsigned HOLD_AFTER   = 150;   // start of the long rsp hold-off
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned STALL_LIMIT  = 2000;

   // ways to spoil a generated record
   typedef enum int {
      FLAW_NONE,
      FLAW_MAGIC,      // one magic character replaced
      FLAW_NO_GAP,     // no whitespace after the magic
      FLAW_SIGN,       // sign in front of the version digits
      FLAW_EMPTY_NUM,  // len= with no digits
      FLAW_OVERFLOW,   // version or crc beyond 32 bits
      FLAW_LENGTH,     // len field disagrees with the body
      FLAW_CRC,        // crc field disagrees with the body
      FLAW_NO_NL,      // header never terminated
      FLAW_CUT,        // header cut short, then newline
      FLAW_NOISE,      // a few random bytes only
      FLAW_NUL         // NUL somewhere before the crc digits
   } flaw_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;

   int unsigned fault_count;
   int unsigned pending_count;
   int unsigned words_sent   = 0;
   int unsigned stall_cycles = 0;
   logic        quiet        = 1'b0;

   logic [7:0]  record_bytes [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   config_envelope_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   envelope_monitor monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   // Append n whitespace characters, drawn from every kind the header allows.
   task automatic push_blanks(input int unsigned n);
      logic [7:0] pick;
      repeat (n) begin
         case ($urandom_range(0, 4))
            0: pick = 8'h09;
            1: pick = 8'h0B;
            2: pick = 8'h0C;
            3: pick = 8'h0D;
            default: pick = 8'h20;
         endcase
         record_bytes.push_back(pick);
      end
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) record_bytes.push_back(8'(s[i]));
   endtask

   // Append a decimal number with some leading zeros.
   task automatic push_dec(input logic [31:0] v, input int unsigned zeros);
      logic [7:0]  digits [$];
      logic [31:0] rest;
      rest = v;
      do begin
         digits.push_front(8'h30 + 8'(rest % 10));
         rest = rest / 10;
      end while (rest != 0);
      repeat (zeros) record_bytes.push_back(8'h30);
      foreach (digits[i]) record_bytes.push_back(digits[i]);
   endtask

   // Build one record into record_bytes: header, newline and body, with the
   // length and CRC fields worked out from the body unless a flaw says otherwise.
   task automatic make_record(input flaw_type flaw, input logic [31:0] version,
                              input int unsigned body_len);
      logic [7:0]  body [$];
      logic [7:0]  c;
      logic [31:0] crc;
      logic [31:0] len_field;
      logic [3:0]  nib;
      int unsigned crc_at;
      int unsigned n;
      logic        spoil_version;
      record_bytes.delete();
      crc = CRC_INIT;
      for (int i = 0; i < body_len; i++) begin
         body.push_back(8'($urandom));
         crc = crc ^ {24'd0, body[i]};
         for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
      end
      crc = ~crc;
      spoil_version = 1'($urandom_range(0, 1));

      if (flaw == FLAW_NOISE) begin
         n = $urandom_range(1, 10);
         repeat (n) record_bytes.push_back(8'($urandom));
      end else begin
         push_blanks($urandom_range(0, 2));
         for (int i = 0; i < 9; i++) record_bytes.push_back(MAGIC_WORD[71 - 8 * i -: 8]);
         if (flaw == FLAW_MAGIC)
            record_bytes[record_bytes.size() - 1 - $urandom_range(0, 8)] = 8'($urandom);
         if (flaw != FLAW_NO_GAP) push_blanks($urandom_range(1, 2));

         push_text("v=");
         push_blanks($urandom_range(0, 1));
         if (flaw == FLAW_SIGN) record_bytes.push_back($urandom_range(0, 1) ? 8'h2B : 8'h2D);
         if (flaw == FLAW_OVERFLOW && spoil_version) push_text("4294967296");
         else push_dec(version, ($urandom_range(0, 3) == 0) ? 1 : 0);
         push_blanks($urandom_range(0, 1));

         push_text("len=");
         push_blanks($urandom_range(0, 1));
         len_field = 32'(body_len);
         if (flaw == FLAW_LENGTH) len_field = len_field ^ (32'd1 << $urandom_range(0, 31));
         if (flaw != FLAW_EMPTY_NUM) push_dec(len_field, ($urandom_range(0, 3) == 0) ? 2 : 0);
         push_blanks($urandom_range(0, 1));

         push_text("crc=0x");
         crc_at = record_bytes.size();
         if (flaw == FLAW_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
         if (flaw == FLAW_OVERFLOW && !spoil_version) begin
            push_text("100000000");
         end else begin
            // drop leading zero nibbles, then maybe put one back; mix the case
            n = 8;
            while (n > 1 && crc[4 * n - 1 -: 4] == 4'd0) n--;
            if ($urandom_range(0, 3) == 0) record_bytes.push_back(8'h30);
            for (int i = int'(n) - 1; i >= 0; i--) begin
               nib = crc[4 * i +: 4];
               if (nib < 4'd10) c = 8'h30 + 8'(nib);
               else c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
               record_bytes.push_back(c);
            end
         end

         // ignored tail of the header line, kept clear of the crc digits
         if ($urandom_range(0, 2) == 0) begin
            push_blanks(1);
            n = $urandom_range(1, 4);
            repeat (n) begin
               c = 8'($urandom);
               record_bytes.push_back((c == CHAR_NL) ? 8'h20 : c);
            end
         end

         if (flaw == FLAW_NUL) record_bytes.insert($urandom_range(0, crc_at - 1), 8'h00);
         if (flaw == FLAW_CUT) begin
            n = $urandom_range(1, record_bytes.size());
            while (record_bytes.size() > n) void'(record_bytes.pop_back());
         end
         if (flaw != FLAW_NO_NL) begin
            record_bytes.push_back(CHAR_NL);
            foreach (body[i]) record_bytes.push_back(body[i]);
         end
      end
   endtask

   // Offer record_bytes word by word, tlast on the final one. Drive at the
   // falling edge, wait for the handshake at the rising edge, and now and then
   // drop tvalid between two words.
   task automatic send_record();
      foreach (record_bytes[i]) begin
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata  <= record_bytes[i];
         req_tlast  <= (i == record_bytes.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         words_sent++;
         if (!quiet && $urandom_range(0, 7) == 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end
      end
   endtask

   // Receiver side: random hold-off bursts, and once a long hold-off so that
   // the block's queue fills and req_tready drops.
   initial begin : rsp_sink
      int unsigned gap;
      int unsigned hold;
      logic        held_once;
      gap       = 0;
      hold      = 0;
      held_once = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && words_sent >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold      = HOLD_CYCLES;
         end
         if (hold != 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (gap != 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("config_envelope_checker_unit test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      flaw_type    flaw;
      logic [31:0] version;
      int unsigned body_len;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: lone NUL, lone 0xFF (both without newline), a bare newline,
      // a blank line followed by body bytes that include a newline, and one
      // clean record at the largest version with an empty body.
      record_bytes = '{8'h00};
      send_record();
      record_bytes = '{8'hFF};
      send_record();
      record_bytes = '{CHAR_NL};
      send_record();
      record_bytes = '{8'h0D, CHAR_NL, 8'hFF, CHAR_NL, 8'h00};
      send_record();
      make_record(FLAW_NONE, 32'hFFFF_FFFF, 0);
      send_record();

      // Random: mostly well-formed records with random content, the rest
      // spoilt in one way each.
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 9) < 6) flaw = FLAW_NONE;
         else flaw = flaw_type'($urandom_range(int'(FLAW_MAGIC), int'(FLAW_NUL)));
         case ($urandom_range(0, 6))
            0: version = 32'd0;
            1: version = 32'd65535;
            2: version = 32'd65536;
            3: version = 32'hFFFF_FFFF;
            4: version = $urandom;
            default: version = $urandom_range(0, 999);
         endcase
         body_len = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
         make_record(flaw, version, body_len);
         if (words_sent >= QUIET_AFTER) quiet = 1'b1;
         send_record();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("config_envelope_checker_unit test passed");
      end else begin
         $display("config_envelope_checker_unit test failed");
      end
      $finish;
   end

endmodule
